FILE: sv/grid_ray_cast_dda_core_assert.svh
// Assertion macros for the ray caster top-level RTL.
`ifndef GRID_RAY_CAST_DDA_CORE_ASSERT_SVH
`define GRID_RAY_CAST_DDA_CORE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define GRCD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("grcd assertion failed");

// The consequent holds in the cycle after the antecedent.
`define GRCD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("grcd assertion failed");

`endif

FILE: sv/grcd_pkg.sv
// ----------------------------------------------------------------------------
// grcd_pkg
// Types and constants shared by the grid ray caster modules.
// ----------------------------------------------------------------------------
`default_nettype none

package grcd_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned CELL_W    = 6;
  localparam int unsigned ADDR_W    = 2 * CELL_W;
  localparam int unsigned MAP_DEPTH = 1 << ADDR_W;
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned POS_W     = 22;
  localparam int unsigned DIR_W     = 19;
  localparam int unsigned DELTA_W   = 31;
  localparam int unsigned SCR_W     = 13;
  localparam int unsigned OFF_W     = 13;
  localparam int unsigned LH_W      = 16;
  localparam int unsigned DE_W      = 17;
  localparam int unsigned WC_W      = 32;
  localparam int unsigned FACE_W    = 3;
  localparam int unsigned MUL_A_W   = 25;
  localparam int unsigned MUL_B_W   = 32;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned SD_W      = 44;
  localparam int unsigned DIV_N     = SCR_W + FRAC_BITS;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [SCR_W-1:0]  SCREEN_RESET = 13'd480;
  localparam logic [CODE_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CODE_W-1:0] CHAR_ONE     = 8'h31;
  localparam logic [CODE_W-1:0] CHAR_P       = 8'h50;

  localparam logic [FACE_W-1:0] FACE_NONE  = 3'd0;
  localparam logic [FACE_W-1:0] FACE_WEST  = 3'd1;
  localparam logic [FACE_W-1:0] FACE_EAST  = 3'd2;
  localparam logic [FACE_W-1:0] FACE_SOUTH = 3'd3;
  localparam logic [FACE_W-1:0] FACE_NORTH = 3'd4;

  typedef enum logic [1:0] {
    MUL_X  = 2'd0,
    MUL_Y  = 2'd1,
    MUL_WC = 2'd2
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    mul_sel_e mul_sel;
    logic     ld_sdx;
    logic     ld_sdy;
    logic     step;
    logic     check;
    logic     perp;
    logic     div;
    logic     fin;
    logic     miss;
  } cmd_t;

  typedef struct packed {
    logic oob;
    logic hit;
    logic steps_max;
    logic div_last;
  } status_t;

endpackage

`default_nettype wire

FILE: sv/grcd_ram.sv
// ----------------------------------------------------------------------------
// grcd_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module grcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/grcd_ctrl.sv
// ----------------------------------------------------------------------------
// grcd_ctrl
// Sequencer for the ray caster: set-up, DDA walk, division, result and miss.
// ----------------------------------------------------------------------------
`default_nettype none

module grcd_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic             operation_i,
  input  wire grcd_pkg::status_t status_i,
  output grcd_pkg::cmd_t        cmd_o,
  output logic                  busy_o
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_INIT_X = 10'b0000000010,
    S_INIT_Y = 10'b0000000100,
    S_INIT_S = 10'b0000001000,
    S_STEP   = 10'b0000010000,
    S_CHECK  = 10'b0000100000,
    S_PERP   = 10'b0001000000,
    S_DIV    = 10'b0010000000,
    S_FIN    = 10'b0100000000,
    S_MISS   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = grcd_pkg::MUL_WC;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = operation_i ? S_INIT_X : S_MISS;
        end
      end
      S_INIT_X: begin
        cmd_o.mul_sel = grcd_pkg::MUL_X;
        state_d       = S_INIT_Y;
      end
      S_INIT_Y: begin
        cmd_o.mul_sel = grcd_pkg::MUL_Y;
        cmd_o.ld_sdx  = 1'b1;
        state_d       = S_INIT_S;
      end
      S_INIT_S: begin
        cmd_o.ld_sdy = 1'b1;
        state_d      = S_STEP;
      end
      S_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = status_i.oob ? S_MISS : S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (status_i.hit) begin
          state_d = S_PERP;
        end else if (status_i.steps_max) begin
          state_d = S_MISS;
        end else begin
          state_d = S_STEP;
        end
      end
      S_PERP: begin
        cmd_o.perp = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        if (status_i.div_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_IDLE;
      end
      S_MISS: begin
        cmd_o.miss = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

FILE: sv/grcd_dp.sv
// ----------------------------------------------------------------------------
// grcd_dp
// Datapath: map store, set-up multiplier, DDA walk, divider and result.
// ----------------------------------------------------------------------------
`default_nettype none

module grcd_dp #(
  parameter int unsigned MAX_STEPS = 128
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire grcd_pkg::cmd_t                       cmd_i,
  output grcd_pkg::status_t                         status_o,
  input  wire logic [grcd_pkg::SCR_W-1:0]           screen_height_i,
  input  wire logic                                 operation_i,
  input  wire logic [grcd_pkg::CELL_W-1:0]          cell_x_i,
  input  wire logic [grcd_pkg::CELL_W-1:0]          cell_y_i,
  input  wire logic [grcd_pkg::CODE_W-1:0]          cell_value_i,
  input  wire logic [grcd_pkg::POS_W-1:0]           pos_x_i,
  input  wire logic [grcd_pkg::POS_W-1:0]           pos_y_i,
  input  wire logic signed [grcd_pkg::DIR_W-1:0]    dir_x_i,
  input  wire logic signed [grcd_pkg::DIR_W-1:0]    dir_y_i,
  input  wire logic [grcd_pkg::DELTA_W-1:0]         delta_x_i,
  input  wire logic [grcd_pkg::DELTA_W-1:0]         delta_y_i,
  input  wire logic signed [grcd_pkg::OFF_W-1:0]    view_offset_i,
  output logic                                      done_o,
  output logic                                      wall_found_o,
  output logic                                      hit_side_o,
  output logic [grcd_pkg::CELL_W-1:0]               hit_cell_x_o,
  output logic [grcd_pkg::CELL_W-1:0]               hit_cell_y_o,
  output logic [grcd_pkg::DELTA_W-1:0]              perp_dist_o,
  output logic [grcd_pkg::LH_W-1:0]                 line_height_o,
  output logic [grcd_pkg::SCR_W-1:0]                draw_start_o,
  output logic signed [grcd_pkg::DE_W-1:0]          draw_end_o,
  output logic signed [grcd_pkg::WC_W-1:0]          wall_hit_coord_o,
  output logic [grcd_pkg::FACE_W-1:0]               face_o
);

  localparam int unsigned STEP_W = $clog2(MAX_STEPS + 1);
  localparam int unsigned CW     = grcd_pkg::CELL_W;
  localparam int unsigned SW     = grcd_pkg::SD_W;
  localparam int unsigned PW     = grcd_pkg::PROD_W;
  localparam int unsigned FB     = grcd_pkg::FRAC_BITS;
  localparam int unsigned DN     = grcd_pkg::DIV_N;

  // Latched item fields.
  logic [CW-1:0]                        cx_q, cy_q;
  logic [grcd_pkg::POS_W-1:0]           px_q, py_q;
  logic signed [grcd_pkg::DIR_W-1:0]    dx_q, dy_q;
  logic [grcd_pkg::DELTA_W-1:0]         ddx_q, ddy_q;
  logic signed [grcd_pkg::OFF_W-1:0]    off_q;

  // Walk and arithmetic state.
  logic signed [SW-1:0]                 sdx_q, sdy_q;
  logic                                 side_q;
  logic [grcd_pkg::CODE_W-1:0]          code_q;
  logic [STEP_W-1:0]                    step_cnt_q;
  logic signed [PW-1:0]                 prod_q;
  logic [grcd_pkg::DELTA_W-1:0]         perp_q;
  logic [DN-1:0]                        quo_q;
  logic [31:0]                          rem_q;
  logic [grcd_pkg::DIV_CNT_W-1:0]       div_cnt_q;
  logic                                 done_q;

  // Result registers.
  logic                                 found_q, oside_q;
  logic [CW-1:0]                        ocx_q, ocy_q;
  logic [grcd_pkg::DELTA_W-1:0]         operp_q;
  logic [grcd_pkg::LH_W-1:0]            lh_q;
  logic [grcd_pkg::SCR_W-1:0]           ds_q;
  logic signed [grcd_pkg::DE_W-1:0]     de_q;
  logic signed [grcd_pkg::WC_W-1:0]     wc_q;
  logic [grcd_pkg::FACE_W-1:0]          face_q;

  logic [grcd_pkg::CODE_W-1:0]          rdata;
  logic [grcd_pkg::ADDR_W-1:0]          raddr;
  logic                                 ram_we;

  logic                                 dx_neg, dy_neg, dx_pos, dy_pos, use_y;
  logic signed [grcd_pkg::MUL_A_W-1:0]  diff_x, diff_y, mul_a;
  logic signed [grcd_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [PW-1:0]                 mul_p;
  logic                                 sd_lt;
  logic [7:0]                           nx, ny;
  logic signed [SW-1:0]                 pd;
  logic [grcd_pkg::DELTA_W-1:0]         perp_d;
  logic [31:0]                          rem_sh;
  logic                                 rem_ge;
  logic [grcd_pkg::LH_W-1:0]            lh;
  logic signed [14:0]                   mid;
  logic signed [16:0]                   ds, de;
  logic signed [42:0]                   wc;
  logic signed [grcd_pkg::WC_W-1:0]     wc_sat;
  logic [grcd_pkg::FACE_W-1:0]          face;

  assign ram_we = cmd_i.load && !operation_i;

  grcd_ram #(
    .WIDTH(grcd_pkg::CODE_W),
    .DEPTH(grcd_pkg::MAP_DEPTH)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i({cell_x_i, cell_y_i}),
    .wdata_i(cell_value_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign dx_neg = dx_q[grcd_pkg::DIR_W-1];
  assign dy_neg = dy_q[grcd_pkg::DIR_W-1];
  assign dx_pos = !dx_neg && (dx_q != '0);
  assign dy_pos = !dy_neg && (dy_q != '0);
  assign use_y  = !side_q && (code_q == grcd_pkg::CHAR_ONE);

  // Distance from the viewer to the first grid line on each axis.
  assign diff_x = dx_neg ? ($signed({3'b000, px_q}) - $signed({3'b000, cx_q, 16'h0000}))
                         : ($signed({2'b00, {1'b0, cx_q} + 7'd1, 16'h0000})
                            - $signed({3'b000, px_q}));
  assign diff_y = dy_neg ? ($signed({3'b000, py_q}) - $signed({3'b000, cy_q, 16'h0000}))
                         : ($signed({2'b00, {1'b0, cy_q} + 7'd1, 16'h0000})
                            - $signed({3'b000, py_q}));

  always_comb begin
    unique case (cmd_i.mul_sel)
      grcd_pkg::MUL_X: begin
        mul_a = diff_x;
        mul_b = $signed({1'b0, ddx_q});
      end
      grcd_pkg::MUL_Y: begin
        mul_a = diff_y;
        mul_b = $signed({1'b0, ddy_q});
      end
      default: begin
        mul_a = use_y ? {{6{dy_q[grcd_pkg::DIR_W-1]}}, dy_q}
                      : {{6{dx_q[grcd_pkg::DIR_W-1]}}, dx_q};
        mul_b = $signed({1'b0, perp_q});
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // One DDA step: advance along the axis whose side distance is smaller.
  assign sd_lt = sdx_q < sdy_q;
  assign nx    = {2'b00, cx_q} + (dx_neg ? 8'hFF : 8'h01);
  assign ny    = {2'b00, cy_q} + (dy_neg ? 8'hFF : 8'h01);
  assign raddr = sd_lt ? {nx[CW-1:0], cy_q} : {cx_q, ny[CW-1:0]};

  assign pd     = side_q ? (sdy_q - $signed({13'd0, ddy_q}))
                         : (sdx_q - $signed({13'd0, ddx_q}));
  assign perp_d = pd[SW-1] ? '0
                : ((pd[SW-2:grcd_pkg::DELTA_W] != '0) ? '1 : pd[grcd_pkg::DELTA_W-1:0]);

  // Restoring divider, one quotient bit a cycle.
  assign rem_sh = {rem_q[30:0], quo_q[DN-1]};
  assign rem_ge = rem_sh >= {1'b0, perp_q};

  // Column projection and wall coordinate.
  assign lh     = (quo_q[DN-1:grcd_pkg::LH_W] != '0) ? '1 : quo_q[grcd_pkg::LH_W-1:0];
  assign mid    = $signed({3'b000, screen_height_i[grcd_pkg::SCR_W-1:1]})
                  + {{2{off_q[grcd_pkg::OFF_W-1]}}, off_q};
  assign ds     = {{2{mid[14]}}, mid} - $signed({2'b00, lh[grcd_pkg::LH_W-1:1]});
  assign de     = {{2{mid[14]}}, mid} + $signed({2'b00, lh[grcd_pkg::LH_W-1:1]});
  assign wc     = {{2{prod_q[PW-1]}}, prod_q[PW-1:FB]}
                  + $signed({21'd0, use_y ? py_q : px_q});
  assign wc_sat = (wc > 43'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF
                : ((wc < -43'sh0_8000_0000) ? 32'sh8000_0000 : wc[31:0]);
  assign face   = use_y ? (dx_pos ? grcd_pkg::FACE_EAST : grcd_pkg::FACE_WEST)
                        : (dy_pos ? grcd_pkg::FACE_SOUTH : grcd_pkg::FACE_NORTH);

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (cmd_i.load) begin
      cx_q  <= cell_x_i;
      cy_q  <= cell_y_i;
      px_q  <= pos_x_i;
      py_q  <= pos_y_i;
      dx_q  <= dir_x_i;
      dy_q  <= dir_y_i;
      ddx_q <= delta_x_i;
      ddy_q <= delta_y_i;
      off_q <= view_offset_i;
    end
    if (cmd_i.ld_sdx) begin
      sdx_q <= {{3{prod_q[PW-1]}}, prod_q[PW-1:FB]};
    end
    if (cmd_i.ld_sdy) begin
      sdy_q <= {{3{prod_q[PW-1]}}, prod_q[PW-1:FB]};
    end
    if (cmd_i.step) begin
      if (sd_lt) begin
        sdx_q  <= sdx_q + $signed({13'd0, ddx_q});
        cx_q   <= nx[CW-1:0];
        side_q <= 1'b0;
      end else begin
        sdy_q  <= sdy_q + $signed({13'd0, ddy_q});
        cy_q   <= ny[CW-1:0];
        side_q <= 1'b1;
      end
    end
    if (cmd_i.check) begin
      code_q <= rdata;
    end
    if (cmd_i.perp) begin
      perp_q    <= perp_d;
      quo_q     <= {screen_height_i, {FB{1'b0}}};
      rem_q     <= '0;
      div_cnt_q <= '0;
    end
    if (cmd_i.div) begin
      rem_q     <= rem_ge ? (rem_sh - {1'b0, perp_q}) : rem_sh;
      quo_q     <= {quo_q[DN-2:0], rem_ge};
      div_cnt_q <= div_cnt_q + 1'b1;
    end
    if (cmd_i.fin) begin
      found_q <= 1'b1;
      oside_q <= side_q;
      ocx_q   <= cx_q;
      ocy_q   <= cy_q;
      operp_q <= perp_q;
      lh_q    <= lh;
      ds_q    <= ds[16] ? '0 : ds[grcd_pkg::SCR_W-1:0];
      de_q    <= (de >= $signed({4'b0000, screen_height_i}))
                 ? ($signed({4'b0000, screen_height_i}) - 17'sd1) : de;
      wc_q    <= wc_sat;
      face_q  <= face;
    end else if (cmd_i.miss) begin
      found_q <= 1'b0;
      oside_q <= 1'b0;
      ocx_q   <= '0;
      ocy_q   <= '0;
      operp_q <= '0;
      lh_q    <= '0;
      ds_q    <= '0;
      de_q    <= '0;
      wc_q    <= '0;
      face_q  <= grcd_pkg::FACE_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_cnt_q <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= cmd_i.fin || cmd_i.miss;
      if (cmd_i.load) begin
        step_cnt_q <= '0;
      end else if (cmd_i.step) begin
        step_cnt_q <= step_cnt_q + 1'b1;
      end
    end
  end

  assign status_o.oob       = sd_lt ? (nx[7:CW] != '0) : (ny[7:CW] != '0);
  assign status_o.hit       = (rdata != grcd_pkg::CHAR_ZERO) && (rdata != grcd_pkg::CHAR_P);
  assign status_o.steps_max = (step_cnt_q == STEP_W'(MAX_STEPS));
  assign status_o.div_last  = (div_cnt_q == grcd_pkg::DIV_CNT_W'(DN - 1));

  assign done_o           = done_q;
  assign wall_found_o     = found_q;
  assign hit_side_o       = oside_q;
  assign hit_cell_x_o     = ocx_q;
  assign hit_cell_y_o     = ocy_q;
  assign perp_dist_o      = operp_q;
  assign line_height_o    = lh_q;
  assign draw_start_o     = ds_q;
  assign draw_end_o       = de_q;
  assign wall_hit_coord_o = wc_q;
  assign face_o           = face_q;

endmodule

`default_nettype wire

FILE: sv/grid_ray_cast_dda_core.sv
// ----------------------------------------------------------------------------
// grid_ray_cast_dda_core
// DDA ray caster over a 64 x 64 character map held in on-chip RAM.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low. Operation 0
// writes one map cell; operation 1 casts a ray from the given cell and
// position. Each item yields one result, shown for a single cycle with
// done_o high; the receiver cannot hold it off. A write item passes
// through the miss state and returns an all-zero result.
// A cast runs through set-up, DDA steps (each a step, then a map
// read), the distance, the bit-serial divider for the column height
// and the result, with at most MAX_STEPS steps. The map RAM read port
// and the bit-serial divider set how long a cast runs. A walk that
// leaves the map finishes early with a no-hit result.
// The screen height register is written through cfg_we_i; the user
// must write it only while idle, as the block does not enforce this.
// Reset returns the sequencer to idle and the screen height to 480; the
// map contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_ray_cast_dda_core #(
  parameter int unsigned MAX_STEPS = 128
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output logic                                      busy_o,
  output logic                                      done_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [grcd_pkg::SCR_W-1:0]           cfg_wdata_i,
  input  wire logic                                 operation_i,
  input  wire logic [grcd_pkg::CELL_W-1:0]          cell_x_i,
  input  wire logic [grcd_pkg::CELL_W-1:0]          cell_y_i,
  input  wire logic [grcd_pkg::CODE_W-1:0]          cell_value_i,
  input  wire logic [grcd_pkg::POS_W-1:0]           pos_x_i,
  input  wire logic [grcd_pkg::POS_W-1:0]           pos_y_i,
  input  wire logic signed [grcd_pkg::DIR_W-1:0]    dir_x_i,
  input  wire logic signed [grcd_pkg::DIR_W-1:0]    dir_y_i,
  input  wire logic [grcd_pkg::DELTA_W-1:0]         delta_x_i,
  input  wire logic [grcd_pkg::DELTA_W-1:0]         delta_y_i,
  input  wire logic signed [grcd_pkg::OFF_W-1:0]    view_offset_i,
  output logic                                      wall_found_o,
  output logic                                      hit_side_o,
  output logic [grcd_pkg::CELL_W-1:0]               hit_cell_x_o,
  output logic [grcd_pkg::CELL_W-1:0]               hit_cell_y_o,
  output logic [grcd_pkg::DELTA_W-1:0]              perp_dist_o,
  output logic [grcd_pkg::LH_W-1:0]                 line_height_o,
  output logic [grcd_pkg::SCR_W-1:0]                draw_start_o,
  output logic signed [grcd_pkg::DE_W-1:0]          draw_end_o,
  output logic signed [grcd_pkg::WC_W-1:0]          wall_hit_coord_o,
  output logic [grcd_pkg::FACE_W-1:0]               face_o
);

`include "grid_ray_cast_dda_core_assert.svh"

  logic [grcd_pkg::SCR_W-1:0] screen_height_q;
  grcd_pkg::cmd_t             cmd;
  grcd_pkg::status_t          status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_height_q <= grcd_pkg::SCREEN_RESET;
    end else if (cfg_we_i) begin
      screen_height_q <= cfg_wdata_i;
    end
  end

  grcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .operation_i(operation_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  grcd_dp #(
    .MAX_STEPS(MAX_STEPS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .screen_height_i (screen_height_q),
    .operation_i     (operation_i),
    .cell_x_i        (cell_x_i),
    .cell_y_i        (cell_y_i),
    .cell_value_i    (cell_value_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .dir_x_i         (dir_x_i),
    .dir_y_i         (dir_y_i),
    .delta_x_i       (delta_x_i),
    .delta_y_i       (delta_y_i),
    .view_offset_i   (view_offset_i),
    .done_o          (done_o),
    .wall_found_o    (wall_found_o),
    .hit_side_o      (hit_side_o),
    .hit_cell_x_o    (hit_cell_x_o),
    .hit_cell_y_o    (hit_cell_y_o),
    .perp_dist_o     (perp_dist_o),
    .line_height_o   (line_height_o),
    .draw_start_o    (draw_start_o),
    .draw_end_o      (draw_end_o),
    .wall_hit_coord_o(wall_hit_coord_o),
    .face_o          (face_o)
  );

  `GRCD_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `GRCD_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy_o)
  `GRCD_ASSERT_NXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o)
  `GRCD_ASSERT_IMP(a_miss_zero, clk_i, rst_ni, done_o && !wall_found_o,
                   perp_dist_o == '0 && face_o == grcd_pkg::FACE_NONE)

endmodule

`default_nettype wire
